### rtl/ale_pkg.sv
`default_nettype none

package ale_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int FUNC_W   = 4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INS_FRONT = 4'd0,
        FUNC_INS_END   = 4'd1,
        FUNC_INS_POS   = 4'd2,
        FUNC_REM_FRONT = 4'd3,
        FUNC_REM_END   = 4'd4,
        FUNC_REM_POS   = 4'd5,
        FUNC_GET_FRONT = 4'd6,
        FUNC_GET_END   = 4'd7,
        FUNC_GET_POS   = 4'd8
    } ale_func_t;

    // Shift command broadcast to every cell of the row
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [IDX_W-1:0] idx;
    } ale_ctrl_t;

endpackage

`default_nettype wire

### rtl/ale_cell.sv
`default_nettype none

module ale_cell
(
    input  wire logic                        clk,
    input  wire ale_pkg::ale_ctrl_t          ctrl,
    input  wire logic [ale_pkg::IDX_W-1:0]   cell_idx,
    input  wire logic [ale_pkg::DATA_W-1:0]  left_value,
    input  wire logic [ale_pkg::DATA_W-1:0]  right_value,
    input  wire logic [ale_pkg::DATA_W-1:0]  new_value,
    output logic      [ale_pkg::DATA_W-1:0]  value
);

    logic [ale_pkg::DATA_W-1:0] value_reg;
    logic [ale_pkg::DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            // Cells past the slot take from the left neighbor; the slot takes the new beat
            if (cell_idx > ctrl.idx)
            begin
                value_next = left_value;
            end
            else if (cell_idx == ctrl.idx)
            begin
                value_next = new_value;
            end
        end
        else if (ctrl.rem)
        begin
            if (cell_idx >= ctrl.idx)
            begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

### rtl/array_list_engine.sv
`default_nettype none

// Ordered list of up to 16 signed 32-bit values, one per cell in a row; on
// insert or remove the cells at and past the slot shift in the same cycle. One
// request is taken per clock; its result (ok flag and value) appears in the
// output register on the next cycle, and s_tready drops only while a result
// waits unaccepted on the master side. Entries are not cleared at reset; only
// the count and m_tvalid are, and no entry at or beyond the count is returned.
module array_list_engine
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // func[3:0], position[8:4], value_in[40:9], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata    // ok[0], value_out[32:1], zero pad
);

    localparam int IDX_W  = ale_pkg::IDX_W;
    localparam int CNT_W  = ale_pkg::CNT_W;
    localparam int DATA_W = ale_pkg::DATA_W;
    localparam int POS_W  = ale_pkg::POS_W;
    localparam int FUNC_W = ale_pkg::FUNC_W;

    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value_in;

    assign func     = s_tdata[FUNC_W-1:0];
    assign position = s_tdata[FUNC_W+POS_W-1:FUNC_W];
    assign value_in = s_tdata[FUNC_W+POS_W+DATA_W-1:FUNC_W+POS_W];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              m_tvalid_reg;
    logic              ok_reg;
    logic [DATA_W-1:0] value_out_reg;

    logic [DATA_W-1:0] entries [ale_pkg::CAPACITY];

    logic              accept;
    logic              full;
    logic              not_empty;
    logic              pos_valid;
    logic [POS_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  count_m1;
    logic              ok;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic [DATA_W-1:0] rd_value;
    ale_pkg::ale_ctrl_t ctrl;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(ale_pkg::CAPACITY));
    assign not_empty = (count_reg != '0);
    assign pos_valid = (position != '0) && (CNT_W'(position) <= count_reg)
                       && (position <= POS_W'(ale_pkg::CAPACITY));
    assign pos_m1    = position - POS_W'(1);
    assign count_m1  = count_reg - CNT_W'(1);

    always_comb
    begin
        ok       = 1'b0;
        rd_en    = 1'b0;
        rd_idx   = '0;
        ctrl.ins = 1'b0;
        ctrl.rem = 1'b0;
        ctrl.idx = '0;
        unique case (func)
            ale_pkg::FUNC_INS_FRONT:
            begin
                ok       = !full;
                ctrl.ins = !full;
                ctrl.idx = '0;
            end
            ale_pkg::FUNC_INS_END:
            begin
                ok       = !full;
                ctrl.ins = !full;
                ctrl.idx = count_reg[IDX_W-1:0];
            end
            ale_pkg::FUNC_INS_POS:
            begin
                ok       = !full && pos_valid;
                ctrl.ins = !full && pos_valid;
                ctrl.idx = pos_m1[IDX_W-1:0];
            end
            ale_pkg::FUNC_REM_FRONT:
            begin
                ok       = not_empty;
                rd_en    = 1'b1;
                rd_idx   = '0;
                ctrl.rem = not_empty;
                ctrl.idx = '0;
            end
            ale_pkg::FUNC_REM_END:
            begin
                ok       = not_empty;
                rd_en    = 1'b1;
                rd_idx   = count_m1[IDX_W-1:0];
                ctrl.rem = not_empty;
                ctrl.idx = count_m1[IDX_W-1:0];
            end
            ale_pkg::FUNC_REM_POS:
            begin
                ok       = pos_valid;
                rd_en    = 1'b1;
                rd_idx   = pos_m1[IDX_W-1:0];
                ctrl.rem = pos_valid;
                ctrl.idx = pos_m1[IDX_W-1:0];
            end
            ale_pkg::FUNC_GET_FRONT:
            begin
                ok     = not_empty;
                rd_en  = 1'b1;
                rd_idx = '0;
            end
            ale_pkg::FUNC_GET_END:
            begin
                ok     = not_empty;
                rd_en  = 1'b1;
                rd_idx = count_m1[IDX_W-1:0];
            end
            ale_pkg::FUNC_GET_POS:
            begin
                ok     = pos_valid;
                rd_en  = 1'b1;
                rd_idx = pos_m1[IDX_W-1:0];
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        // Hold the row unless a request is actually taken
        if (!accept)
        begin
            ctrl.ins = 1'b0;
            ctrl.rem = 1'b0;
        end
    end

    assign rd_value = entries[rd_idx];

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.rem)
        begin
            count_next = count_m1;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < ale_pkg::CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_value;
            logic [DATA_W-1:0] right_value;

            if (gi == 0)
            begin : g_first
                assign left_value = '0;
            end
            else
            begin : g_inner_l
                assign left_value = entries[gi-1];
            end

            if (gi == ale_pkg::CAPACITY - 1)
            begin : g_last
                assign right_value = '0;
            end
            else
            begin : g_inner_r
                assign right_value = entries[gi+1];
            end

            ale_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .cell_idx    (IDX_W'(gi)),
                .left_value  (left_value),
                .right_value (right_value),
                .new_value   (value_in),
                .value       (entries[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg        <= ok;
            value_out_reg <= (ok && rd_en) ? rd_value : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, value_out_reg, ok_reg};

endmodule

`default_nettype wire

### rtl/ale_checker.sv
`default_nettype none

module ale_port_props
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [47:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    // A stalled result beat stays presented
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // Every accepted request produces a result beat on the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request gave no result");

    // A failed result carries a zero value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0)
        else $error("failed result with nonzero value");

    // Unused function codes always fail
    a_bad_func: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[3:0] > ale_pkg::FUNC_GET_POS)
        |=> m_tvalid && !m_tdata[0])
        else $error("unused function code succeeded");

    // Position zero fails for every positional operation
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[8:4] == 5'd0)
        && (s_tdata[3:0] == ale_pkg::FUNC_INS_POS || s_tdata[3:0] == ale_pkg::FUNC_REM_POS
            || s_tdata[3:0] == ale_pkg::FUNC_GET_POS)
        |=> m_tvalid && !m_tdata[0])
        else $error("positional request at position zero succeeded");

endmodule

bind array_list_engine ale_port_props u_ale_port_props
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### test/ale_checker.sv
`timescale 1ns / 1ps

module ale_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // func[3:0], position[8:4], value_in[40:9], zero pad
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,   // ok[0], value_out[32:1], zero pad
    output int               fail_count,
    output int               pending_count
);

    localparam int CAPACITY = ale_pkg::CAPACITY;
    localparam int DATA_W   = ale_pkg::DATA_W;
    localparam int POS_W    = ale_pkg::POS_W;
    localparam int FUNC_W   = ale_pkg::FUNC_W;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] value;
    } list_result_t;

    // Shadow copy of the list
    logic signed [DATA_W-1:0] shadow_list [CAPACITY];
    int unsigned              shadow_count = 0;
    list_result_t             awaited_results [$];
    int unsigned              result_index = 0;

    initial fail_count = 0;
    initial pending_count = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH beat %0d: %s", $time, result_index, msg);
        fail_count++;
    endtask

    function automatic void insert_at(input int unsigned idx, input logic signed [31:0] v);
        for (int unsigned i = shadow_count; i > idx; i--)
            shadow_list[i] = shadow_list[i - 1];
        shadow_list[idx] = v;
        shadow_count++;
    endfunction

    function automatic logic signed [31:0] take_at(input int unsigned idx);
        logic signed [31:0] v;
        v = shadow_list[idx];
        for (int unsigned i = idx; i + 1 < shadow_count; i++)
            shadow_list[i] = shadow_list[i + 1];
        shadow_count--;
        return v;
    endfunction

    function automatic list_result_t apply_request(input logic [FUNC_W-1:0] f,
                                                   input logic [POS_W-1:0]  p,
                                                   input logic signed [31:0] v);
        list_result_t r;
        bit           is_full;
        bit           pos_ok;
        r       = '0;
        is_full = (shadow_count >= CAPACITY);
        pos_ok  = (p >= 1) && (p <= shadow_count);
        case (f)
            ale_pkg::FUNC_INS_FRONT:
                if (!is_full)
                begin
                    insert_at(0, v);
                    r.ok = 1'b1;
                end
            ale_pkg::FUNC_INS_END:
                if (!is_full)
                begin
                    insert_at(shadow_count, v);
                    r.ok = 1'b1;
                end
            ale_pkg::FUNC_INS_POS:
                if (!is_full && pos_ok)
                begin
                    insert_at(p - 1, v);
                    r.ok = 1'b1;
                end
            ale_pkg::FUNC_REM_FRONT:
                if (shadow_count > 0)
                begin
                    r.value = take_at(0);
                    r.ok    = 1'b1;
                end
            ale_pkg::FUNC_REM_END:
                if (shadow_count > 0)
                begin
                    r.value = take_at(shadow_count - 1);
                    r.ok    = 1'b1;
                end
            ale_pkg::FUNC_REM_POS:
                if (pos_ok)
                begin
                    r.value = take_at(p - 1);
                    r.ok    = 1'b1;
                end
            ale_pkg::FUNC_GET_FRONT:
                if (shadow_count > 0)
                begin
                    r.value = shadow_list[0];
                    r.ok    = 1'b1;
                end
            ale_pkg::FUNC_GET_END:
                if (shadow_count > 0)
                begin
                    r.value = shadow_list[shadow_count - 1];
                    r.ok    = 1'b1;
                end
            ale_pkg::FUNC_GET_POS:
                if (pos_ok)
                begin
                    r.value = shadow_list[p - 1];
                    r.ok    = 1'b1;
                end
            default:
                ;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin : watch_channels
        list_result_t want;
        if (rst_n)
        begin
            // results first: a beat accepted now belongs to an earlier request
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("result with nothing awaited: ok=%0b value_out=%0d",
                                              m_tdata[0], $signed(m_tdata[32:1])));
                else
                begin
                    want = awaited_results.pop_front();
                    if (m_tdata[0] !== want.ok)
                        report_mismatch($sformatf("ok got %0b want %0b", m_tdata[0], want.ok));
                    if (m_tdata[32:1] !== want.value)
                        report_mismatch($sformatf("value_out got %0d want %0d",
                                                  $signed(m_tdata[32:1]), want.value));
                end
                result_index++;
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(apply_request(s_tdata[3:0], s_tdata[8:4],
                                                        s_tdata[40:9]));
            pending_count <= awaited_results.size();
        end
    end

endmodule

### test/tb_array_list_engine.sv
`timescale 1ns / 1ps

module tb_array_list_engine;

    localparam int CAPACITY = ale_pkg::CAPACITY;
    localparam int DATA_W   = ale_pkg::DATA_W;
    localparam int POS_W    = ale_pkg::POS_W;
    localparam int FUNC_W   = ale_pkg::FUNC_W;

    typedef enum {PH_SLOW_SINK, PH_SLOW_SOURCE, PH_FREE} idle_phase_t;
    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} list_mode_t;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 4'd9;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 4'd15;
    localparam int RANDOM_ITEMS  = 1880;
    localparam int RUN_LENGTH    = 20;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 8;
    localparam int WATCHDOG_MAX  = 4000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // func[3:0], position[8:4], value_in[40:9], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // ok[0], value_out[32:1], zero pad

    int          fail_count;
    int          pending_count;
    int unsigned tx_idle_pct  = 11;
    int unsigned rx_idle_pct  = 87;
    idle_phase_t phase        = PH_SLOW_SINK;
    idle_phase_t held_phase   = PH_SLOW_SINK;
    int          stall_left   = 0;
    int          quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    array_list_engine dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ale_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Sink side: long hold-off on every phase change, random stalls otherwise
    always @(posedge clk)
    begin
        if (phase != held_phase)
        begin
            held_phase <= phase;
            stall_left <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                             input logic [DATA_W-1:0] v);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, v, p, f};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic logic [DATA_W-1:0] random_value();
        if ($urandom_range(99) < 10)
        begin
            case ($urandom_range(3))
                0:       return 32'h7fff_ffff;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [FUNC_W-1:0] random_func(input list_mode_t mode);
        int unsigned roll;
        roll = $urandom_range(99);
        case (mode)
            MODE_FILL:
                if (roll < 40)      return ale_pkg::FUNC_INS_END;
                else if (roll < 65) return ale_pkg::FUNC_INS_FRONT;
                else if (roll < 85) return ale_pkg::FUNC_INS_POS;
            MODE_DRAIN:
                if (roll < 30)      return ale_pkg::FUNC_REM_FRONT;
                else if (roll < 55) return ale_pkg::FUNC_REM_END;
                else if (roll < 80) return ale_pkg::FUNC_REM_POS;
            default:
                // unused selectors as noise
                if (roll < 5)       return FUNC_W'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
        endcase
        return FUNC_W'($urandom_range(ale_pkg::FUNC_GET_POS, ale_pkg::FUNC_INS_FRONT));
    endfunction

    initial
    begin
        list_mode_t         mode;
        int unsigned        roll;
        logic [POS_W-1:0]   pos;

        mode = MODE_FILL;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every remove, the front and positional reads, a positional insert and an unused code fail
        send_item(ale_pkg::FUNC_GET_FRONT, 5'd1, 32'd0);
        send_item(ale_pkg::FUNC_REM_FRONT, 5'd1, 32'd0);
        send_item(ale_pkg::FUNC_REM_END, 5'd1, 32'd0);
        send_item(ale_pkg::FUNC_REM_POS, 5'd1, 32'd0);
        send_item(ale_pkg::FUNC_GET_POS, 5'd1, 32'd0);
        send_item(ale_pkg::FUNC_INS_POS, 5'd1, 32'd5);
        send_item(FUNC_UNUSED_HI, 5'd1, 32'd7);
        // build [min, -1, max]
        send_item(ale_pkg::FUNC_INS_END, 5'd0, 32'h7fff_ffff);
        send_item(ale_pkg::FUNC_INS_FRONT, 5'd0, 32'h8000_0000);
        send_item(ale_pkg::FUNC_INS_POS, 5'd2, 32'hffff_ffff);
        send_item(ale_pkg::FUNC_INS_POS, 5'd0, 32'd1);
        send_item(ale_pkg::FUNC_INS_POS, 5'd4, 32'd2);
        send_item(ale_pkg::FUNC_GET_POS, 5'd3, 32'd0);
        send_item(ale_pkg::FUNC_GET_POS, 5'd0, 32'd0);
        send_item(ale_pkg::FUNC_GET_POS, 5'd31, 32'd0);
        send_item(ale_pkg::FUNC_GET_FRONT, 5'd0, 32'd0);
        send_item(ale_pkg::FUNC_GET_END, 5'd0, 32'd0);
        send_item(FUNC_UNUSED_LO, 5'd31, 32'hffff_ffff);
        send_item(ale_pkg::FUNC_REM_POS, 5'd0, 32'd0);
        send_item(ale_pkg::FUNC_REM_POS, 5'd2, 32'd0);
        send_item(ale_pkg::FUNC_REM_FRONT, 5'd0, 32'd0);
        send_item(ale_pkg::FUNC_REM_END, 5'd0, 32'd0);
        send_item(ale_pkg::FUNC_GET_END, 5'd0, 32'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                phase       <= PH_SLOW_SOURCE;
                rx_idle_pct <= 11;
                tx_idle_pct  = 87;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                phase       <= PH_FREE;
                rx_idle_pct <= 0;
                tx_idle_pct  = 0;
            end
            if (n % RUN_LENGTH == 0)
            begin
                roll = $urandom_range(99);
                mode = (roll < 35) ? MODE_FILL : (roll < 65) ? MODE_DRAIN : MODE_MIX;
            end
            // mostly in-range positions, some zero or past the capacity
            pos = ($urandom_range(99) < 85) ? POS_W'($urandom_range(CAPACITY, 1))
                                            : POS_W'($urandom_range(31));
            send_item(random_func(mode), pos, random_value());
        end
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
rtl/ale_pkg.sv
rtl/ale_cell.sv
rtl/array_list_engine.sv
rtl/ale_checker.sv
test/ale_checker.sv
test/tb_array_list_engine.sv
